FILE: rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants for the staged free-list allocator
// Handle layout, word structs, operation codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfla_pkg;

  // Handle layout: stage number above element number
  localparam int unsigned STAGE_BITS   = 2;
  localparam int unsigned ELEMENT_BITS = 10;
  localparam int unsigned HANDLE_BITS  = STAGE_BITS + ELEMENT_BITS;
  localparam int unsigned LINK_DEPTH   = 1 << HANDLE_BITS;

  // Register widths: one extra bit so the full count fits
  localparam int unsigned CAP_BITS    = ELEMENT_BITS + 1;
  localparam int unsigned STG_BITS    = STAGE_BITS + 1;
  localparam int unsigned ESIZE_BITS  = 16;
  localparam int unsigned OFFSET_BITS = ELEMENT_BITS + ESIZE_BITS;
  localparam int unsigned CFG_DATA_BITS = ESIZE_BITS;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam logic [CAP_BITS-1:0] MAX_CAP = CAP_BITS'(1 << ELEMENT_BITS);
  localparam logic [STG_BITS-1:0] MAX_STG = STG_BITS'(1 << STAGE_BITS);

  // Operation codes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESOLVE = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STAGE_CAPACITY = 2'd0,
    REG_MAX_STAGES     = 2'd1,
    REG_ELEMENT_SIZE   = 2'd2
  } reg_idx_e;

  // Input word
  typedef struct packed {
    logic [1:0]              op;
    logic [STAGE_BITS-1:0]   handle_stage;
    logic [ELEMENT_BITS-1:0] handle_element;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [STAGE_BITS-1:0]   out_stage;
    logic [ELEMENT_BITS-1:0] out_element;
    logic [OFFSET_BITS-1:0]  byte_offset;
    logic                    status;
  } out_word_t;

endpackage

FILE: rtl/sfla_ram.sv
// ----------------------------------------------------------------------------
// sfla_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfla_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/staged_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// staged_free_list_allocator_unit: staged free-list handle allocator
// Pipeline: input register, then result register; a word is accepted into the
//   input register and moves to the result register when the process stage fires.
// Throughput: one word per cycle unless the output stalls; a pop's link RAM read
//   returns in time for the next word, so back-to-back pops run at full rate.
// Reset: empty list, stage 0 open at element 1, registers at defaults, no RAM clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module staged_free_list_allocator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  sfla_pkg::in_word_t                   in_word_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output sfla_pkg::out_word_t                  out_word_o,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sfla_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [sfla_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);

  import sfla_pkg::*;

  // Configuration registers
  logic [CAP_BITS-1:0]   cap_q;
  logic [STG_BITS-1:0]   max_stg_q;
  logic [ESIZE_BITS-1:0] esize_q;

  // Pipeline registers
  logic      in_valid_q;
  in_word_t  in_q;
  logic      out_valid_q;
  out_word_t out_q, out_d;

  // Allocator state
  logic [HANDLE_BITS-1:0] head_q, head_d;
  logic [HANDLE_BITS-1:0] head_link_q, head_link_d;
  logic                   link_ram_q, link_ram_d;
  logic [STG_BITS-1:0]    stages_q, stages_d;
  logic [CAP_BITS-1:0]    bump_q, bump_d;

  // Control
  logic                   advance;
  logic                   fire;
  logic [HANDLE_BITS-1:0] head_link;
  logic [HANDLE_BITS-1:0] ram_rdata;
  logic                   ram_we;
  logic                   ram_re;
  logic [HANDLE_BITS-1:0] in_handle;
  logic [CAP_BITS-1:0]    eff_cap;
  logic [STG_BITS-1:0]    eff_stg;
  logic [OFFSET_BITS-1:0] offset;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= '0;
      max_stg_q <= '0;
      esize_q   <= ESIZE_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STAGE_CAPACITY: cap_q     <= cfg_wdata_i[CAP_BITS-1:0];
        REG_MAX_STAGES:     max_stg_q <= cfg_wdata_i[STG_BITS-1:0];
        REG_ELEMENT_SIZE:   esize_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the process stage moves when the result register is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  // Effective limits; zero or oversize values saturate to the build maximum
  assign eff_cap = (cap_q == '0 || cap_q > MAX_CAP) ? MAX_CAP : cap_q;
  assign eff_stg = (max_stg_q == '0 || max_stg_q > MAX_STG) ? MAX_STG : max_stg_q;

  // Link of the current head: from the RAM right after a pop, else tracked
  assign head_link = link_ram_q ? ram_rdata : head_link_q;
  assign in_handle = {in_q.handle_stage, in_q.handle_element};
  assign offset    = OFFSET_BITS'(in_q.handle_element) * OFFSET_BITS'(esize_q);

  // Process one word: result and next state
  always_comb begin
    out_d       = '0;
    head_d      = head_q;
    head_link_d = head_link_q;
    link_ram_d  = link_ram_q;
    stages_d    = stages_q;
    bump_d      = bump_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (in_q.op)
      OP_ALLOC: begin
        if (head_q != '0) begin
          // pop the list head and fetch the new head's link
          out_d.out_stage   = head_q[HANDLE_BITS-1:ELEMENT_BITS];
          out_d.out_element = head_q[ELEMENT_BITS-1:0];
          head_d            = head_link;
          link_ram_d        = 1'b1;
          ram_re            = 1'b1;
        end else if (bump_q < eff_cap) begin
          // bump within the open stage
          out_d.out_stage   = STAGE_BITS'(stages_q - STG_BITS'(1));
          out_d.out_element = bump_q[ELEMENT_BITS-1:0];
          bump_d            = bump_q + CAP_BITS'(1);
        end else if (stages_q < eff_stg) begin
          // open a new stage at element zero
          out_d.out_stage   = stages_q[STAGE_BITS-1:0];
          out_d.out_element = '0;
          stages_d          = stages_q + STG_BITS'(1);
          bump_d            = CAP_BITS'(1);
        end else begin
          out_d.status = 1'b1;
        end
      end
      OP_FREE: begin
        // push without check
        ram_we      = 1'b1;
        head_d      = in_handle;
        head_link_d = head_q;
        link_ram_d  = 1'b0;
      end
      OP_RESOLVE: begin
        out_d.out_stage   = in_q.handle_stage;
        out_d.out_element = in_q.handle_element;
        out_d.byte_offset = offset;
      end
      default: ;
    endcase
  end

  // Allocator state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      head_link_q <= '0;
      link_ram_q  <= 1'b0;
      stages_q    <= STG_BITS'(1);
      bump_q      <= CAP_BITS'(1);
    end else if (fire) begin
      head_q      <= head_d;
      head_link_q <= head_link_d;
      link_ram_q  <= link_ram_d;
      stages_q    <= stages_d;
      bump_q      <= bump_d;
    end
  end

  // Next-link memory
  sfla_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (fire && ram_we),
    .waddr_i (in_handle),
    .wdata_i (head_q),
    .re_i    (fire && ram_re),
    .raddr_i (head_link),
    .rdata_o (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |->
      out_word_o.out_stage == '0 && out_word_o.out_element == '0)
    else $error("failed allocate returned a non-null handle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.op == OP_ALLOC && head_q != '0 |=> link_ram_q)
    else $error("pop did not switch head link to RAM data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stages_q != '0 && stages_q <= MAX_STG)
    else $error("stage count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result register was free");

endmodule
